[rtl/slrp_pkg.sv]
// Shared constants, angle table and pipeline sideband type for the quaternion slerp block.
package slrp_pkg;

   localparam int FRAC_BITS = 15;
   localparam int WORK_BITS = 30;
   localparam int FIELD_W   = 16;
   localparam int CFG_W     = 15;
   localparam int WORK_W    = WORK_BITS + 1;
   localparam int XW        = 35;
   localparam int ZW        = 33;
   localparam int SQRT_STAGES = 31;
   localparam int DIV_STAGES  = 32;

   localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 15'd32764;
   localparam logic [WORK_W-1:0] WORK_ONE        = 31'd1073741824;
   localparam logic signed [XW-1:0] CORDIC_GAIN_INV = 35'sd652032874;

   localparam logic [29:0] ATAN_TAB [0:31] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
      30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
      30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
      30'd262144,    30'd131072,    30'd65536,     30'd32768,
      30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,
      30'd64,        30'd32,        30'd16,        30'd8,
      30'd4,         30'd2,         30'd1,         30'd0
   };

   typedef struct packed {
      logic [3:0][FIELD_W-1:0] p;
      logic [3:0][FIELD_W-1:0] q;
      logic [WORK_W-1:0]       tt;
      logic                    neg;
      logic                    lin;
      logic [WORK_W-1:0]       c;
      logic [WORK_W-1:0]       s;
   } side_type;

endpackage

[rtl/quaternion_slerp.sv]
// The pipeline holds the square root, the two CORDIC chains and the 32-step divider,
// each one step per stage.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Reset clears all valid bits and loads thr_ff with 32764.
// Top level of the quaternion slerp pipeline.
module quaternion_slerp import slrp_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_p_w,
   input  logic signed [FIELD_W-1:0] req_p_x,
   input  logic signed [FIELD_W-1:0] req_p_y,
   input  logic signed [FIELD_W-1:0] req_p_z,
   input  logic signed [FIELD_W-1:0] req_q_w,
   input  logic signed [FIELD_W-1:0] req_q_x,
   input  logic signed [FIELD_W-1:0] req_q_y,
   input  logic signed [FIELD_W-1:0] req_q_z,
   input  logic        [FIELD_W-1:0] req_blend,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_r_w,
   output logic signed [FIELD_W-1:0] rsp_r_x,
   output logic signed [FIELD_W-1:0] rsp_r_y,
   output logic signed [FIELD_W-1:0] rsp_r_z,
   input  logic                      csr_wr_en,
   input  logic        [CFG_W-1:0]   csr_wr_data
);

   localparam int S_PROD   = 0;
   localparam int S_DOT    = 1;
   localparam int S_SQ     = 2;
   localparam int S_REM    = 3;
   localparam int SQ0      = 4;
   localparam int SQE      = SQ0 + SQRT_STAGES - 1;
   localparam int AT0      = SQE + 1;
   localparam int ANG      = AT0 + CORDIC_STAGES;
   localparam int SN0      = ANG + 1;
   localparam int DIV_INIT = SN0 + CORDIC_STAGES;
   localparam int DIV_LAST = DIV_INIT + DIV_STAGES;
   localparam int S_SEL    = DIV_LAST + 1;
   localparam int S_MUL    = S_SEL + 1;
   localparam int S_OUT    = S_MUL + 1;
   localparam int TOTAL    = S_OUT + 1;

   logic                 en;
   logic [CFG_W-1:0]     thr_ff;
   logic [TOTAL-1:0]     vld_ff;
   side_type             sb_ff [TOTAL];
   side_type             sb_in [TOTAL];

   assign en        = !vld_ff[TOTAL-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_valid};
      end
   end

   // dot product
   logic [FIELD_W-1:0]   bl;
   logic signed [31:0]   prod_ff [4];
   logic signed [33:0]   dot;
   logic [33:0]          mag;
   logic [WORK_W-1:0]    c_in;
   logic                 neg_in, lin_in;

   assign bl = (req_blend > 16'd32768) ? 16'd32768 : req_blend;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= req_p_w * req_q_w;
         prod_ff[1] <= req_p_x * req_q_x;
         prod_ff[2] <= req_p_y * req_q_y;
         prod_ff[3] <= req_p_z * req_q_z;
      end
   end

   assign dot = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
   assign neg_in = dot < 0;
   assign mag    = neg_in ? 34'(-dot) : 34'(dot);
   assign c_in   = (mag > 34'(WORK_ONE)) ? WORK_ONE : mag[WORK_W-1:0];
   assign lin_in = c_in > {1'b0, thr_ff, {(WORK_BITS-FRAC_BITS){1'b0}}};

   // sine of the angle: 1 - c^2, then square root
   logic [61:0]          csq_ff;
   logic [60:0]          s2_ff;
   logic [60:0]          sn_ff [SQRT_STAGES];
   logic [WORK_W-1:0]    sr_ff [SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         csq_ff <= sb_ff[S_DOT].c * sb_ff[S_DOT].c;
         s2_ff  <= (61'd1 << (2 * WORK_BITS)) - csq_ff[60:0];
      end
   end

   genvar j;
   generate
      for (j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
         localparam int K = SQRT_STAGES - 1 - j;
         logic [60:0]       np, n_in;
         logic [WORK_W-1:0] rp, r_in;
         logic [61:0]       trial;
         logic              ge;
         if (j == 0) begin : g_first
            assign np = s2_ff;
            assign rp = '0;
         end else begin : g_next
            assign np = sn_ff[j-1];
            assign rp = sr_ff[j-1];
         end
         assign trial = (62'(rp) << (K + 1)) + (62'd1 << (2 * K));
         assign ge    = {1'b0, np} >= trial;
         assign n_in  = ge ? np - trial[60:0] : np;
         assign r_in  = ge ? (rp | (WORK_W'(1) << K)) : rp;
         always_ff @(posedge clock) begin
            if (en) begin
               sn_ff[j] <= n_in;
               sr_ff[j] <= r_in;
            end
         end
      end
   endgenerate

   // angle by atan2
   logic signed [XW-1:0] at_x, at_y;
   logic signed [ZW-1:0] at_z;
   logic [31:0]          om;

   slrp_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_atan (
      .clock   (clock),
      .en      (en),
      .x_start ($signed(XW'(sb_ff[SQE].c))),
      .y_start ($signed(XW'(sr_ff[SQRT_STAGES-1]))),
      .z_start ('0),
      .x_end   (at_x),
      .y_end   (at_y),
      .z_end   (at_z)
   );

   assign om = (at_z < 0) ? 32'd0 : at_z[31:0];

   logic [62:0]          am0, am1;
   logic signed [ZW-1:0] a0_ff, a1_ff;

   assign am0 = (WORK_ONE - sb_ff[ANG-1].tt) * om;
   assign am1 = sb_ff[ANG-1].tt * om;

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= $signed({1'b0, am0[61:30]});
         a1_ff <= $signed({1'b0, am1[61:30]});
      end
   end

   // sine of the partial angles
   logic signed [XW-1:0] sn0_x, sn0_y, sn1_x, sn1_y;
   logic signed [ZW-1:0] sn0_z, sn1_z;

   slrp_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_sin0 (
      .clock   (clock),
      .en      (en),
      .x_start (CORDIC_GAIN_INV),
      .y_start ('0),
      .z_start (a0_ff),
      .x_end   (sn0_x),
      .y_end   (sn0_y),
      .z_end   (sn0_z)
   );

   slrp_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_sin1 (
      .clock   (clock),
      .en      (en),
      .x_start (CORDIC_GAIN_INV),
      .y_start ('0),
      .z_start (a1_ff),
      .x_end   (sn1_x),
      .y_end   (sn1_y),
      .z_end   (sn1_z)
   );

   // weight = (sine << 30) / sin, one quotient bit per stage
   logic signed [XW-1:0] sine [2];
   logic [WORK_W-1:0]    wsph [2];

   assign sine[0] = sn0_y;
   assign sine[1] = sn1_y;

   genvar l, d;
   generate
      for (l = 0; l < 2; l++) begin : g_lane
         logic [63:0] rem_ff [DIV_STAGES+1];
         logic [31:0] quo_ff [DIV_STAGES+1];
         logic        ovf_ff [DIV_STAGES+1];
         logic [33:0] sv;

         assign sv = (sine[l] < 0) ? 34'd0 : sine[l][33:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[0] <= {sv, {WORK_BITS{1'b0}}};
               quo_ff[0] <= '0;
               ovf_ff[0] <= sv >= (34'(sb_ff[DIV_INIT-1].s) << 2);
            end
         end

         for (d = 1; d <= DIV_STAGES; d++) begin : g_div
            localparam int K = DIV_STAGES - d;
            logic [63:0] dsh, rem_in;
            logic [31:0] quo_in;
            logic        ge;
            assign dsh    = 64'(sb_ff[DIV_INIT + d - 1].s) << K;
            assign ge     = rem_ff[d-1] >= dsh;
            assign rem_in = ge ? rem_ff[d-1] - dsh : rem_ff[d-1];
            assign quo_in = ge ? (quo_ff[d-1] | (32'd1 << K)) : quo_ff[d-1];
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[d] <= rem_in;
                  quo_ff[d] <= quo_in;
                  ovf_ff[d] <= ovf_ff[d-1];
               end
            end
         end

         assign wsph[l] = (ovf_ff[DIV_STAGES] || quo_ff[DIV_STAGES] > 32'(WORK_ONE))
                          ? WORK_ONE : quo_ff[DIV_STAGES][WORK_W-1:0];
      end
   endgenerate

   // weight select, products, rounding and saturation
   logic [WORK_W-1:0]    k0_ff, k1_ff;
   logic                 use_lin;
   logic signed [47:0]   pk_ff [4];
   logic signed [47:0]   qk_ff [4];
   logic [FIELD_W-1:0]   r_ff [4];
   logic [FIELD_W-1:0]   r_in [4];

   assign use_lin = sb_ff[S_SEL-1].lin || (sb_ff[S_SEL-1].s == '0);

   always_ff @(posedge clock) begin
      if (en) begin
         k0_ff <= use_lin ? WORK_ONE - sb_ff[S_SEL-1].tt : wsph[0];
         k1_ff <= use_lin ? sb_ff[S_SEL-1].tt : wsph[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            pk_ff[i] <= $signed(sb_ff[S_MUL-1].p[i]) * $signed({1'b0, k0_ff});
            qk_ff[i] <= $signed(sb_ff[S_MUL-1].q[i]) * $signed({1'b0, k1_ff});
         end
      end
   end

   always_comb begin
      logic signed [49:0] acc;
      logic signed [19:0] sh;
      for (int i = 0; i < 4; i++) begin
         acc = 50'(pk_ff[i]) + (sb_ff[S_OUT-1].neg ? -50'(qk_ff[i]) : 50'(qk_ff[i]))
               + (50'sd1 <<< (WORK_BITS - 1));
         sh  = 20'(acc >>> WORK_BITS);
         if (sh > 20'sd32767) begin
            r_in[i] = 16'h7fff;
         end else if (sh < -20'sd32768) begin
            r_in[i] = 16'h8000;
         end else begin
            r_in[i] = sh[FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            r_ff[i] <= r_in[i];
         end
      end
   end

   assign rsp_r_w = $signed(r_ff[0]);
   assign rsp_r_x = $signed(r_ff[1]);
   assign rsp_r_y = $signed(r_ff[2]);
   assign rsp_r_z = $signed(r_ff[3]);

   // sideband travels with every stage
   always_comb begin
      sb_in[0].p   = {req_p_z, req_p_y, req_p_x, req_p_w};
      sb_in[0].q   = {req_q_z, req_q_y, req_q_x, req_q_w};
      sb_in[0].tt  = WORK_W'(bl) << (WORK_BITS - FRAC_BITS);
      sb_in[0].neg = 1'b0;
      sb_in[0].lin = 1'b0;
      sb_in[0].c   = '0;
      sb_in[0].s   = '0;
      for (int i = 1; i < TOTAL; i++) begin
         sb_in[i] = sb_ff[i-1];
      end
      sb_in[S_DOT].c   = c_in;
      sb_in[S_DOT].neg = neg_in;
      sb_in[S_DOT].lin = lin_in;
      sb_in[AT0].s     = sr_ff[SQRT_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < TOTAL; i++) begin
            sb_ff[i] <= sb_in[i];
         end
      end
   end

endmodule

[rtl/slrp_cordic.sv]
// Unrolled CORDIC pipeline, vectoring (atan2) or rotation (sine), one iteration per stage.
module slrp_cordic import slrp_pkg::*; #(
   parameter int STAGES = 16,
   parameter bit VECTOR = 1'b0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] x_start,
   input  logic signed [XW-1:0] y_start,
   input  logic signed [ZW-1:0] z_start,
   output logic signed [XW-1:0] x_end,
   output logic signed [XW-1:0] y_end,
   output logic signed [ZW-1:0] z_end
);

   logic signed [XW-1:0] x_ff [STAGES];
   logic signed [XW-1:0] y_ff [STAGES];
   logic signed [ZW-1:0] z_ff [STAGES];

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_stage
         logic signed [XW-1:0] xp, yp, x_in, y_in, xs, ys;
         logic signed [ZW-1:0] zp, z_in, ang;
         logic                 dir;
         if (i == 0) begin : g_first
            assign xp = x_start;
            assign yp = y_start;
            assign zp = z_start;
         end else begin : g_next
            assign xp = x_ff[i-1];
            assign yp = y_ff[i-1];
            assign zp = z_ff[i-1];
         end
         assign ang  = $signed({{(ZW-30){1'b0}}, ATAN_TAB[i]});
         assign xs   = xp >>> i;
         assign ys   = yp >>> i;
         assign dir  = VECTOR ? (yp < 0) : (zp >= 0);
         assign x_in = dir ? xp - ys : xp + ys;
         assign y_in = dir ? yp + xs : yp - xs;
         assign z_in = dir ? zp - ang : zp + ang;
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i] <= x_in;
               y_ff[i] <= y_in;
               z_ff[i] <= z_in;
            end
         end
      end
   endgenerate

   assign x_end = x_ff[STAGES-1];
   assign y_end = y_ff[STAGES-1];
   assign z_end = z_ff[STAGES-1];

endmodule

[bench/quaternion_slerp_test.sv]
// Self-checking testbench for the quaternion slerp pipeline: random and directed rotations.
`timescale 1ns / 100ps
module quaternion_slerp_test;
   import slrp_pkg::*;

   typedef struct {
      logic signed [15:0] p [4];
      logic signed [15:0] q [4];
      logic [15:0] blend;
   } rot_pair_type;

   typedef struct {
      logic signed [15:0] r [4];
   } rot_result_type;

   localparam longint ONE_W = 64'd1 << 30;
   localparam longint ANGLES [0:31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
   localparam int STAGES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_p_w = '0, req_p_x = '0, req_p_y = '0, req_p_z = '0;
   logic signed [15:0] req_q_w = '0, req_q_x = '0, req_q_y = '0, req_q_z = '0;
   logic [15:0] req_blend = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   logic [CFG_W-1:0] threshold;
   rot_result_type pending_rots [$];
   int errors = 0;
   bit no_idle = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   quaternion_slerp u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_p_w(req_p_w), .req_p_x(req_p_x), .req_p_y(req_p_y), .req_p_z(req_p_z),
      .req_q_w(req_q_w), .req_q_x(req_q_x), .req_q_y(req_q_y), .req_q_z(req_q_z),
      .req_blend(req_blend),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_r_w(rsp_r_w), .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic longint shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint arc_angle(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr(y, i); ny = y - shr(x, i); z = z + ANGLES[i];
         end else begin
            nx = x - shr(y, i); ny = y + shr(x, i); z = z - ANGLES[i];
         end
         x = nx; y = ny;
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint arc_sine(longint a);
      longint x, y, nx, ny;
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (a >= 0) begin
            nx = x - shr(y, i); ny = y + shr(x, i); a = a - ANGLES[i];
         end else begin
            nx = x + shr(y, i); ny = y - shr(x, i); a = a + ANGLES[i];
         end
         x = nx; y = ny;
      end
      return (y < 0) ? 0 : y;
   endfunction

   function automatic longint sine_weight(longint angle, longint s);
      longint unsigned k;
      k = (longint'(arc_sine(angle)) << 30) / longint'(s);
      return (k > ONE_W) ? ONE_W : longint'(k);
   endfunction

   function automatic rot_result_type slerp_blend(rot_pair_type it);
      rot_result_type res;
      longint p [4], q [4];
      longint dot, c, tt, thr, k0, k1, s, om, a0, a1, acc;
      longint unsigned bl;
      dot = 0;
      for (int i = 0; i < 4; i++) begin
         p[i] = it.p[i]; q[i] = it.q[i];
         dot = dot + p[i] * q[i];
      end
      if (dot < 0) begin
         for (int i = 0; i < 4; i++) q[i] = -q[i];
         dot = -dot;
      end
      c = (dot > ONE_W) ? ONE_W : dot;
      bl = (it.blend > 16'd32768) ? 32768 : it.blend;
      tt = longint'(bl) << 15;
      thr = longint'(threshold) << 15;
      k0 = ONE_W - tt;
      k1 = tt;
      if (c <= thr) begin
         s = root64((64'd1 << 60) - c * c);
         if (s > 0) begin
            om = arc_angle(s, c);
            a0 = ((ONE_W - tt) * om) >> 30;
            a1 = (tt * om) >> 30;
            k0 = sine_weight(a0, s);
            k1 = sine_weight(a1, s);
         end
      end
      for (int i = 0; i < 4; i++) begin
         acc = shr(p[i] * k0 + q[i] * k1 + (64'd1 << 29), 30);
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         res.r[i] = acc[15:0];
      end
      return res;
   endfunction

   task automatic send_pair(rot_pair_type it);
      while (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_p_w, req_p_x, req_p_y, req_p_z} <= {it.p[0], it.p[1], it.p[2], it.p[3]};
      {req_q_w, req_q_x, req_q_y, req_q_z} <= {it.q[0], it.q[1], it.q[2], it.q[3]};
      req_blend <= it.blend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rots.push_back(slerp_blend(it));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rots.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_threshold(logic [CFG_W-1:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold = v;
   endtask

   function automatic rot_pair_type unit_pair(int deg_range);
      rot_pair_type it;
      real a [4], b [4], na, nb, d;
      for (int i = 0; i < 4; i++) a[i] = $itor($signed($urandom_range(2000))) - 1000.0;
      d = $itor($urandom_range(deg_range)) / 1000.0;
      for (int i = 0; i < 4; i++) b[i] = a[i] + d * ($itor($urandom_range(2000)) - 1000.0);
      na = 0; nb = 0;
      for (int i = 0; i < 4; i++) begin
         na = na + a[i] * a[i]; nb = nb + b[i] * b[i];
      end
      if (na < 1.0) begin a[0] = 1000.0; na = 1.0e6; end
      if (nb < 1.0) begin b[0] = 1000.0; nb = 1.0e6; end
      na = $sqrt(na); nb = $sqrt(nb);
      for (int i = 0; i < 4; i++) begin
         it.p[i] = 16'($rtoi(a[i] / na * 32767.0));
         it.q[i] = 16'($rtoi(b[i] / nb * 32767.0));
      end
      if ($urandom_range(1)) for (int i = 0; i < 4; i++) it.q[i] = -it.q[i];
      it.blend = 16'($urandom_range(32768));
      return it;
   endfunction

   function automatic rot_pair_type raw_pair();
      rot_pair_type it;
      for (int i = 0; i < 4; i++) begin
         it.p[i] = 16'($urandom); it.q[i] = 16'($urandom);
      end
      it.blend = 16'($urandom);
      return it;
   endfunction

   task automatic test_directed();
      rot_pair_type it;
      logic signed [15:0] ext [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 4; i++) begin
            it.p[i] = ext[(k + i) % 4]; it.q[i] = ext[(k + 3 * i) % 4];
         end
         it.blend = (k % 2) ? 16'hffff : 16'h0000;
         send_pair(it);
      end
      it.p = '{16'sd32767, 0, 0, 0};
      foreach (ext[j]) begin
         it.q = '{16'sd32767, 0, 0, 0};
         it.blend = (j == 0) ? 16'd32768 : (j == 1) ? 16'd16384 : 16'(32769 + j);
         send_pair(it);
      end
      it.q = '{16'sd0, 16'sd32767, 0, 0};
      send_pair(it);
      it.q = '{-16'sd32767, 0, 0, 0};
      send_pair(it);
      it.q = '{16'sd23170, 16'sd23170, 0, 0};
      send_pair(it);
      it.p = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      it.q = it.p;
      send_pair(it);
      for (int i = 0; i < 6; i++) send_pair(unit_pair(1000));
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n > count / 3 && n < count / 2) no_idle = 1'b1;
         else no_idle = 1'b0;
         if ($urandom_range(9) < 8) send_pair(unit_pair($urandom_range(1) ? 30 : 2000));
         else send_pair(raw_pair());
      end
      no_idle = 1'b0;
   endtask

   task automatic test_thresholds();
      write_threshold(15'd0);
      test_random(40);
      write_threshold(15'h7fff);
      test_random(40);
      write_threshold(15'd30000);
      test_random(40);
      write_threshold(THRESHOLD_RESET);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 13);
         if (rsp_valid && rsp_ready) begin
            if (pending_rots.size() == 0) begin
               $display("%0t: unexpected result %h %h %h %h", $time,
                        rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z);
               errors++;
            end else begin
               rot_result_type e;
               logic signed [15:0] got [4];
               e = pending_rots.pop_front();
               got = '{rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z};
               for (int i = 0; i < 4; i++)
                  if (got[i] !== e.r[i]) begin
                     $display("%0t: r[%0d] expected %h actual %h", $time, i, e.r[i], got[i]);
                     errors++;
                  end
            end
         end
      end
   end

   initial begin
      threshold = THRESHOLD_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(210);
      drain_results();
      test_random(100);
      test_thresholds();
      drain_results();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #200000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
